[design/tcce_pkg.sv]
// Shared types, constants and helpers of the text console cursor engine.
// Used by tcce_ctrl, tcce_dp, the top level and the testbench; depends on nothing else.
`default_nettype none

package tcce_pkg;

   // Screen geometry.
   localparam int COLUMNS   = 80;
   localparam int ROWS      = 25;
   localparam int TAB_WIDTH = 8;
   localparam int CELLS     = ROWS * COLUMNS;

   // Field widths fixed by the interface.
   localparam int FUNC_W  = 2;
   localparam int CHAR_W  = 8;
   localparam int COLOR_W = 4;
   localparam int INDEX_W = 11;
   localparam int LOC_W   = 11;
   localparam int CELL_W  = 16;

   // Internal widths.
   localparam int ADDR_W = $clog2(CELLS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COLX_W = $clog2(COLUMNS + TAB_WIDTH);
   localparam int ROWX_W = $clog2(ROWS + 1);

   localparam logic [COLX_W-1:0] COLUMNS_X   = COLX_W'(COLUMNS);
   localparam logic [ROWX_W-1:0] ROWS_X      = ROWX_W'(ROWS);
   localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);
   localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] COPY_CELLS  = ADDR_W'(CELLS - COLUMNS);
   localparam logic [ADDR_W-1:0] ROW_STRIDE  = ADDR_W'(COLUMNS);

   localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

   // Control characters.
   localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUT   = 2'd0,
      FUNC_CLEAR = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      KIND_DONE,
      KIND_READ,
      KIND_SWEEP
   } item_kind_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_SWEEP,
      ST_DRAIN
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take_item;
      logic sweep_start;
      logic sweep_run;
      logic rsp_read;
      logic rsp_sweep;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      item_kind_type item_kind;
      logic          sweep_last;
      logic          rsp_free;
   } status_type;

   function automatic logic is_printable(input logic [CHAR_W-1:0] code);
      return (code[7] == 1'b0) && (code[6:5] != 2'b00);
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      return ADDR_W'(ADDR_W'(row) * ROW_STRIDE) + ADDR_W'(col);
   endfunction

endpackage

`default_nettype wire

[design/tcce_ram.sv]
// Generic single-clock RAM: one write port, one read port with registered data.
// Stand-alone; depends on nothing.
`default_nettype none

module tcce_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/tcce_ctrl.sv]
// Controller state machine of the text console cursor engine.
// Depends on tcce_pkg; drives the datapath through cmd_type, reads status_type.
`default_nettype none

module tcce_ctrl
   import tcce_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire status_type status,
   output      cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      reply_ff, reply_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         reply_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         reply_ff <= reply_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      reply_in  = reply_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_INIT: begin
            // Blank the whole store after reset; no transfer goes out.
            cmd.sweep_run = 1'b1;
            reply_in      = 1'b0;
            if (status.sweep_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_IDLE: begin
            req_stall = !status.rsp_free;
            if (req_valid && status.rsp_free) begin
               cmd.take_item = 1'b1;
               unique case (status.item_kind)
                  KIND_READ: state_in = ST_READ;
                  KIND_SWEEP: begin
                     cmd.sweep_start = 1'b1;
                     reply_in        = 1'b1;
                     state_in        = ST_SWEEP;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ: begin
            cmd.rsp_read = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_SWEEP: begin
            cmd.sweep_run = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // The last delayed write lands in this cycle.
            cmd.rsp_sweep = reply_ff;
            state_in      = ST_IDLE;
         end
         default: state_in = ST_INIT;
      endcase
   end

endmodule

`default_nettype wire

[design/tcce_dp.sv]
// Datapath of the text console cursor engine: cursor, cell store, sweep
// engine for scroll and clear, and the result register.
// Depends on tcce_pkg and tcce_ram.
`default_nettype none

module tcce_dp
   import tcce_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   output      status_type         status,
   input  wire logic [FUNC_W-1:0]  req_func,
   input  wire logic [CHAR_W-1:0]  req_char_code,
   input  wire logic [COLOR_W-1:0] req_back_color,
   input  wire logic [COLOR_W-1:0] req_fore_color,
   input  wire logic [INDEX_W-1:0] req_cell_index,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic [LOC_W-1:0]   rsp_cursor_pos,
   output      logic [CELL_W-1:0]  rsp_cell_value,
   output      logic               rsp_scrolled
);

   func_type      func;
   item_kind_type item_kind;

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COLX_W-1:0] col_x;
   logic [ROWX_W-1:0] row_x;
   logic              need_scroll;
   logic [ADDR_W-1:0] cur_addr, next_addr;

   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic              copy_ff, copy_in;
   logic              pend_valid_ff;
   logic [ADDR_W-1:0] pend_addr_ff;
   logic              pend_copy_ff;
   logic              sweep_rd;
   logic              read_hit;
   logic              read_ok_ff;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [CELL_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [CELL_W-1:0] rd_data;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [LOC_W-1:0]  rsp_loc_ff;
   logic [CELL_W-1:0] rsp_value_ff;
   logic              rsp_scrolled_ff;
   logic              load_now;

   assign func = func_type'(req_func);

   // Next cursor position for the item at the input.
   always_comb begin
      col_x = COLX_W'(col_ff);
      row_x = ROWX_W'(row_ff);
      unique case (func)
         FUNC_PUT: begin
            priority if (req_char_code == CH_BS) begin
               if (col_ff != '0) begin
                  col_x = col_x - 1'b1;
               end
            end else if (req_char_code == CH_TAB) begin
               col_x = COLX_W'((col_x / TAB_WIDTH + 1'b1) * TAB_WIDTH);
            end else if (req_char_code == CH_CR) begin
               col_x = '0;
            end else if (req_char_code == CH_LF) begin
               col_x = '0;
               row_x = row_x + 1'b1;
            end else if (is_printable(req_char_code)) begin
               col_x = col_x + 1'b1;
            end else begin
               // Other bytes leave the cursor where it is.
               col_x = COLX_W'(col_ff);
            end
            if (col_x >= COLUMNS_X) begin
               col_x = '0;
               row_x = row_x + 1'b1;
            end
         end
         FUNC_CLEAR: begin
            col_x = '0;
            row_x = '0;
         end
         default: begin
            col_x = COLX_W'(col_ff);
            row_x = ROWX_W'(row_ff);
         end
      endcase
      need_scroll = (row_x >= ROWS_X);
      col_in      = COL_W'(col_x);
      row_in      = need_scroll ? LAST_ROW : ROW_W'(row_x);
   end

   assign cur_addr  = cell_addr(row_ff, col_ff);
   assign next_addr = cell_addr(row_in, col_in);

   always_comb begin
      unique case (func)
         FUNC_READ:  item_kind = KIND_READ;
         FUNC_CLEAR: item_kind = KIND_SWEEP;
         FUNC_PUT:   item_kind = need_scroll ? KIND_SWEEP : KIND_DONE;
         default:    item_kind = KIND_DONE;
      endcase
   end

   assign status.item_kind  = item_kind;
   assign status.sweep_last = (sweep_ff == LAST_CELL);
   assign status.rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Sweep engine: reads the cell one row below and writes it on the next cycle,
   // or writes blanks where nothing is copied.
   assign sweep_rd = cmd.sweep_run && copy_ff && (sweep_ff < COPY_CELLS);
   assign read_hit = cmd.take_item && (func == FUNC_READ) && (32'(req_cell_index) < CELLS);

   always_comb begin
      sweep_in = sweep_ff;
      copy_in  = copy_ff;
      if (cmd.sweep_start) begin
         sweep_in = '0;
         copy_in  = (func == FUNC_PUT);
      end else if (cmd.sweep_run) begin
         sweep_in = sweep_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff      <= '0;
         copy_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         col_ff        <= '0;
         row_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         sweep_ff      <= sweep_in;
         copy_ff       <= copy_in;
         pend_valid_ff <= cmd.sweep_run;
         rsp_valid_ff  <= rsp_valid_in;
         if (cmd.take_item) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= sweep_ff;
      pend_copy_ff <= sweep_rd;
      if (cmd.take_item) begin
         read_ok_ff <= read_hit;
      end
   end

   always_comb begin
      if (pend_valid_ff) begin
         wr_en   = 1'b1;
         wr_addr = pend_addr_ff;
         wr_data = pend_copy_ff ? rd_data : BLANK_CELL;
      end else begin
         wr_en   = cmd.take_item && (func == FUNC_PUT) && is_printable(req_char_code);
         wr_addr = cur_addr;
         wr_data = {req_back_color, req_fore_color, req_char_code};
      end
   end

   assign rd_en   = sweep_rd || read_hit;
   assign rd_addr = cmd.sweep_run ? (sweep_ff + ROW_STRIDE) : ADDR_W'(req_cell_index);

   tcce_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Result register. The controller loads it only when it is free.
   assign load_now = cmd.take_item && (item_kind == KIND_DONE);

   always_comb begin
      if (load_now || cmd.rsp_read || cmd.rsp_sweep) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load_now) begin
         rsp_loc_ff      <= LOC_W'(next_addr);
         rsp_value_ff    <= '0;
         rsp_scrolled_ff <= 1'b0;
      end else if (cmd.rsp_read) begin
         rsp_loc_ff      <= LOC_W'(cur_addr);
         rsp_value_ff    <= read_ok_ff ? rd_data : '0;
         rsp_scrolled_ff <= 1'b0;
      end else if (cmd.rsp_sweep) begin
         rsp_loc_ff      <= LOC_W'(cur_addr);
         rsp_value_ff    <= '0;
         rsp_scrolled_ff <= copy_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_pos = rsp_loc_ff;
   assign rsp_cell_value = rsp_value_ff;
   assign rsp_scrolled   = rsp_scrolled_ff;

endmodule

`default_nettype wire

[design/text_console_cursor_engine.sv]
// Text console cursor engine: an 80x25 cell store with cursor handling.
// The request channel takes put-character, clear and read items; each item
// returns one transfer on the response channel with the cursor location,
// the cell word for a read, and a flag set when the item scrolled the screen.
// After reset the block blanks all 2000 cells to 0x0F20, one cell a cycle,
// and holds req_stall high until that is done.
// A put character that does not scroll, and an unused function code, give
// their result in the cycle after acceptance; the block then takes one item
// per cycle while rsp_stall is low. A read passes through the registered read
// port of the cell store and then the result register. A scroll or a clear
// walks the whole store through its one write port, a scroll also copying
// through its one read port, one cell a cycle, and answers once the walk is done.
// The result sits in an output register; a new item is taken only when that
// register is empty or being emptied in the same cycle, so while rsp_stall
// is held against a waiting result the block stops taking items and the result holds its value.
// Depends on tcce_pkg, tcce_ctrl, tcce_dp and tcce_ram.
`default_nettype none

module text_console_cursor_engine
   import tcce_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic [FUNC_W-1:0]  req_func,
   input  wire logic [CHAR_W-1:0]  req_char_code,
   input  wire logic [COLOR_W-1:0] req_back_color,
   input  wire logic [COLOR_W-1:0] req_fore_color,
   input  wire logic [INDEX_W-1:0] req_cell_index,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic [LOC_W-1:0]   rsp_cursor_pos,
   output      logic [CELL_W-1:0]  rsp_cell_value,
   output      logic               rsp_scrolled
);

   cmd_type    cmd;
   status_type status;

   tcce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tcce_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_func       (req_func),
      .req_char_code  (req_char_code),
      .req_back_color (req_back_color),
      .req_fore_color (req_fore_color),
      .req_cell_index (req_cell_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_cell_value (rsp_cell_value),
      .rsp_scrolled   (rsp_scrolled)
   );

endmodule

`default_nettype wire

[tb/sv/text_console_cursor_engine_tb.sv]
// Testbench for the text console cursor engine: directed and random console
// traffic under several idle patterns, checked against a shadow screen.
// Depends on tcce_pkg and text_console_cursor_engine.
`timescale 1ns / 100ps

module text_console_cursor_engine_tb
   import tcce_pkg::*;
();

   localparam logic [CHAR_W-1:0] PRINT_FIRST = 8'h20;
   localparam logic [CHAR_W-1:0] PRINT_LAST  = 8'h7F;
   localparam int RANDOM_PER_PHASE = 135;
   localparam int PHASE_COUNT      = 4;
   localparam int REPORT_LIMIT     = 10;
   localparam int DRAIN_CYCLES     = 50;
   // A scroll or clear walks all 2000 cells, and so does the blanking after
   // reset; the limit leaves ample room over that.
   localparam int WATCHDOG_LIMIT   = 12000;

   typedef struct packed {
      func_type             func;
      logic [CHAR_W-1:0]    char_code;
      logic [COLOR_W-1:0]   back_color;
      logic [COLOR_W-1:0]   fore_color;
      logic [INDEX_W-1:0]   cell_index;
   } console_request_type;

   typedef struct packed {
      logic [LOC_W-1:0]  cursor_pos;
      logic [CELL_W-1:0] cell_value;
      logic              scrolled;
   } console_response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [FUNC_W-1:0]  req_func;
   logic [CHAR_W-1:0]  req_char_code;
   logic [COLOR_W-1:0] req_back_color;
   logic [COLOR_W-1:0] req_fore_color;
   logic [INDEX_W-1:0] req_cell_index;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [LOC_W-1:0]   rsp_cursor_pos;
   logic [CELL_W-1:0]  rsp_cell_value;
   logic               rsp_scrolled;

   console_request_type  driven_request = '0;
   console_request_type  queued_requests[$];
   console_response_type expected_responses[$];

   // Shadow copy of the screen and cursor.
   logic [CELL_W-1:0] shadow_screen [CELLS];
   int                shadow_col;
   int                shadow_row;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int failure_count  = 0;
   int quiet_cycles   = 0;

   assign req_func       = driven_request.func;
   assign req_char_code  = driven_request.char_code;
   assign req_back_color = driven_request.back_color;
   assign req_fore_color = driven_request.fore_color;
   assign req_cell_index = driven_request.cell_index;

   text_console_cursor_engine dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_char_code  (req_char_code),
      .req_back_color (req_back_color),
      .req_fore_color (req_fore_color),
      .req_cell_index (req_cell_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_cell_value (rsp_cell_value),
      .rsp_scrolled   (rsp_scrolled)
   );

   always #5 clock = ~clock;

   function automatic console_request_type request(input func_type f, input int code,
                                                   input int back, input int fore,
                                                   input int idx);
      console_request_type r;
      r.func       = f;
      r.char_code  = CHAR_W'(code);
      r.back_color = COLOR_W'(back);
      r.fore_color = COLOR_W'(fore);
      r.cell_index = INDEX_W'(idx);
      return r;
   endfunction

   function automatic void blank_shadow_screen();
      for (int i = 0; i < CELLS; i++) begin
         shadow_screen[i] = BLANK_CELL;
      end
   endfunction

   // Applies one request to the shadow screen and returns the response it gives.
   function automatic console_response_type apply_console_item(input console_request_type r);
      console_response_type res;
      res = '0;
      case (r.func)
         FUNC_PUT: begin
            if (r.char_code == CH_BS) begin
               if (shadow_col != 0) shadow_col--;
            end else if (r.char_code == CH_TAB) begin
               shadow_col = (shadow_col / TAB_WIDTH + 1) * TAB_WIDTH;
            end else if (r.char_code == CH_CR) begin
               shadow_col = 0;
            end else if (r.char_code == CH_LF) begin
               shadow_col = 0;
               shadow_row++;
            end else if (r.char_code >= PRINT_FIRST && r.char_code <= PRINT_LAST) begin
               shadow_screen[shadow_row * COLUMNS + shadow_col] =
                  {r.back_color, r.fore_color, r.char_code};
               shadow_col++;
            end
            if (shadow_col >= COLUMNS) begin
               shadow_col = 0;
               shadow_row++;
            end
            if (shadow_row >= ROWS) begin
               for (int i = 0; i < CELLS - COLUMNS; i++) begin
                  shadow_screen[i] = shadow_screen[i + COLUMNS];
               end
               for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
                  shadow_screen[i] = BLANK_CELL;
               end
               shadow_row   = ROWS - 1;
               res.scrolled = 1'b1;
            end
         end
         FUNC_CLEAR: begin
            blank_shadow_screen();
            shadow_col = 0;
            shadow_row = 0;
         end
         FUNC_READ: begin
            if (r.cell_index < CELLS) res.cell_value = shadow_screen[r.cell_index];
         end
         default: ;
      endcase
      res.cursor_pos = LOC_W'(shadow_row * COLUMNS + shadow_col);
      return res;
   endfunction

   // Request driver: a new item goes out only once the current one is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) expected_responses.push_back(apply_console_item(driven_request));
         if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            driven_request <= queued_requests.pop_front();
            req_valid      <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      console_response_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_responses.size() == 0) begin
               if (failure_count < REPORT_LIMIT)
                  $display("unexpected transfer: cursor %0d cell_value %h scrolled %b",
                           rsp_cursor_pos, rsp_cell_value, rsp_scrolled);
               failure_count++;
            end else begin
               want = expected_responses.pop_front();
               if (rsp_cursor_pos !== want.cursor_pos ||
                   rsp_cell_value !== want.cell_value || rsp_scrolled !== want.scrolled) begin
                  if (failure_count < REPORT_LIMIT) begin
                     $display("mismatch: cursor expected %0d got %0d",
                              want.cursor_pos, rsp_cursor_pos);
                     $display("          cell_value expected %h got %h, scrolled %b got %b",
                              want.cell_value, rsp_cell_value, want.scrolled, rsp_scrolled);
                  end
                  failure_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      int counted;
      int kind;
      int run;
      int back;
      int fore;
      int pick;

      blank_shadow_screen();
      shadow_col = 0;
      shadow_row = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         @(negedge clock);
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
            default: begin send_idle_pct = 7; recv_stall_pct = 7; end
         endcase

         if (phase == 0) begin
            queued_requests.push_back(request(FUNC_READ, 0, 0, 0, 0));
            queued_requests.push_back(request(FUNC_READ, 255, 15, 15, 2047));
            queued_requests.push_back(request(FUNC_PUT, 8'h41, 15, 15, 2047));
            queued_requests.push_back(request(FUNC_PUT, PRINT_FIRST, 0, 0, 0));
            queued_requests.push_back(request(FUNC_PUT, PRINT_LAST, 10, 5, 1365));
            queued_requests.push_back(request(FUNC_READ, 0, 0, 0, 0));
            queued_requests.push_back(request(FUNC_PUT, CH_BS, 3, 4, 0));
            // Ignored bytes: a plain control byte and the high half.
            queued_requests.push_back(request(FUNC_PUT, 8'h00, 1, 2, 0));
            queued_requests.push_back(request(FUNC_PUT, 8'h80, 1, 2, 0));
            queued_requests.push_back(request(FUNC_PUT, 8'hFF, 1, 2, 0));
            queued_requests.push_back(request(FUNC_NONE, 8'h41, 15, 15, 2047));
            queued_requests.push_back(request(FUNC_PUT, CH_CR, 0, 0, 0));
            queued_requests.push_back(request(FUNC_PUT, CH_BS, 0, 0, 0));
            queued_requests.push_back(request(FUNC_PUT, CH_LF, 0, 0, 0));
            // Ten tabs from column zero, the last one wrapping to the next row.
            for (int k = 0; k < 10; k++) begin
               queued_requests.push_back(request(FUNC_PUT, CH_TAB, 0, 0, 0));
            end
            queued_requests.push_back(request(FUNC_CLEAR, 8'h41, 15, 15, 2047));
            queued_requests.push_back(request(FUNC_READ, 0, 0, 0, 0));
         end

         // Ignored items do not count toward the phase total.
         counted = 0;
         while (counted < RANDOM_PER_PHASE) begin
            kind = $urandom_range(99);
            back = $urandom_range(15);
            fore = $urandom_range(15);
            if (kind < 35) begin
               run = $urandom_range(40, 1);
               for (int k = 0; k < run; k++) begin
                  queued_requests.push_back(request(FUNC_PUT,
                     $urandom_range(PRINT_LAST, PRINT_FIRST), back, fore, $urandom));
               end
               counted += run;
            end else if (kind < 50) begin
               run = $urandom_range(8, 1);
               for (int k = 0; k < run; k++) begin
                  queued_requests.push_back(request(FUNC_PUT,
                     ($urandom_range(4) == 0) ? CH_CR : CH_LF, back, fore, $urandom));
               end
               counted += run;
            end else if (kind < 58) begin
               run = $urandom_range(12, 1);
               for (int k = 0; k < run; k++) begin
                  queued_requests.push_back(request(FUNC_PUT, CH_TAB, back, fore, $urandom));
               end
               counted += run;
            end else if (kind < 65) begin
               if ($urandom_range(2) == 0) begin
                  queued_requests.push_back(request(FUNC_PUT, CH_CR, back, fore, $urandom));
                  counted++;
               end
               run = $urandom_range(10, 1);
               for (int k = 0; k < run; k++) begin
                  queued_requests.push_back(request(FUNC_PUT, CH_BS, back, fore, $urandom));
               end
               counted += run;
            end else if (kind < 85) begin
               run = $urandom_range(6, 1);
               for (int k = 0; k < run; k++) begin
                  // Text mostly collects in the bottom rows once the screen scrolls.
                  pick = $urandom_range(9);
                  if (pick < 6) pick = $urandom_range(CELLS - 1, CELLS - 2 * COLUMNS);
                  else if (pick < 9) pick = $urandom_range(CELLS - 1);
                  else pick = $urandom_range(2047, CELLS);
                  queued_requests.push_back(request(FUNC_READ, $urandom, $urandom,
                                                    $urandom, pick));
               end
               counted += run;
            end else if (kind < 87) begin
               queued_requests.push_back(request(FUNC_CLEAR, $urandom, $urandom,
                                                 $urandom, $urandom));
               counted++;
            end else begin
               case ($urandom_range(2))
                  0: queued_requests.push_back(request(FUNC_PUT, $urandom_range(8'h1F),
                                                       back, fore, $urandom));
                  1: queued_requests.push_back(request(FUNC_PUT, $urandom_range(255, 128),
                                                       back, fore, $urandom));
                  default: queued_requests.push_back(request(FUNC_NONE, $urandom,
                                                             back, fore, $urandom));
               endcase
            end
         end

         while (queued_requests.size() != 0 || req_valid || expected_responses.size() != 0)
            @(negedge clock);
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failure_count == 0 && expected_responses.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
